// ===== rtl/swr_pkg.sv =====
// Shared types and codes for the sliding window reorder receiver.
// Request and result structs, packet and result kinds, reorder store records.
// No dependencies.
`timescale 1ns / 1ps

package swr_pkg;

  // packet types
  localparam logic [1:0] PT_START = 2'd0;
  localparam logic [1:0] PT_END   = 2'd1;
  localparam logic [1:0] PT_DATA  = 2'd2;
  localparam logic [1:0] PT_ACK   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_DELIVER = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_FINAL   = 2'd2;

  // configuration register indexes
  typedef logic [0:0] cfg_addr_t;
  localparam cfg_addr_t CFG_WINDOW = 1'b0;
  localparam cfg_addr_t CFG_MODE   = 1'b1;
  localparam int        CFG_DW     = 5;

  localparam logic [4:0] WINDOW_RST = 5'd8;
  // longest run of buffered deliveries after one in-order packet
  localparam logic [4:0] MAX_DRAIN  = 5'd31;

  typedef struct packed {
    logic        header_ok;
    logic [1:0]  packet_type;
    logic [31:0] seq;
    logic [10:0] payload_len;
    logic [15:0] payload_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] ack_seq;
    logic [15:0] out_tag;
    logic [10:0] out_len;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [10:0] len;
  } slot_data_t;

  typedef struct packed {
    logic wr;   // store record at write index and mark it full
    logic rd;   // read record at read index
    logic clr;  // mark read index empty
  } store_cmd_t;

  typedef struct packed {
    logic wr_full;
    logic rd_full;
  } store_sts_t;

endpackage

// ===== rtl/swr_store.sv =====
// Reorder store: per-slot full flags plus a tag/length memory with registered read.
// Depends on swr_pkg.
`timescale 1ns / 1ps

module swr_store #(
  parameter int REORDER_SLOTS = 32,
  parameter int IDXW          = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swr_pkg::store_cmd_t  cmd,
  input  logic [IDXW-1:0]      waddr,
  input  swr_pkg::slot_data_t  wdata,
  input  logic [IDXW-1:0]      raddr,
  output swr_pkg::slot_data_t  rdata,
  output swr_pkg::store_sts_t  sts
);
  import swr_pkg::*;

  logic [REORDER_SLOTS-1:0] full_r;
  slot_data_t               mem_r [REORDER_SLOTS];
  slot_data_t               rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
    end else begin
      if (cmd.wr) begin
        full_r[waddr] <= 1'b1;
      end
      if (cmd.clr) begin
        full_r[raddr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_r[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata       = rdata_r;
  assign sts.wr_full = full_r[waddr];
  assign sts.rd_full = full_r[raddr];

endmodule

// ===== rtl/sliding_window_reorder_receiver.sv =====
// Top level of the sliding window reorder receiver: sequencer, shared adder, config.
// Depends on swr_pkg and swr_store.
`timescale 1ns / 1ps

// Receiving side of a windowed reliable transfer.
// Requests: a packet header on in_req is taken at a clock edge where start is
// high and busy is low. Results appear on out_rsp for exactly one cycle with
// out_valid high; the receiver always takes them. out_rsp.last marks the final
// result of a request.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the window span (index 0) and
// the ack mode (index 1); write only while busy is low and no result is pending.
// Timing: one 33-bit adder serves every sequence compare and increment.
// The opening request and requests dropped without a check (bad header, start
// or ack type, closed session) finish in ST_IDLE; the opening ack follows next cycle.
// A checked packet passes ST_CMP, also when the window check drops it; a stored
// or acked-only packet gets its ack registered from ST_CMP. An in-order data
// packet gets its delivery registered from ST_CMP, then each buffered successor
// goes through ST_INC, ST_PROBE and ST_READ (increment, slot probe, memory
// read), and the closing ack comes from a last ST_INC and ST_PROBE.
// Reset returns to the waiting phase, expected number zero, store empty,
// window 8 and cumulative acks.
module sliding_window_reorder_receiver #(
  parameter int REORDER_SLOTS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  swr_pkg::req_t               in_req,
  output logic                        out_valid,
  output swr_pkg::rsp_t               out_rsp,
  input  logic                        cfg_we,
  input  swr_pkg::cfg_addr_t          cfg_addr,
  input  logic [swr_pkg::CFG_DW-1:0]  cfg_wdata
);
  import swr_pkg::*;

  localparam int              IDXW     = (REORDER_SLOTS > 1) ? $clog2(REORDER_SLOTS) : 1;
  localparam logic [IDXW:0]   SLOTS_W  = (IDXW + 1)'(REORDER_SLOTS);
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(REORDER_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_INC,
    ST_PROBE,
    ST_READ
  } state_t;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_OPEN,
    PH_CLOSED
  } phase_t;

  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  logic [31:0]     expected_r, expected_nxt;
  logic [IDXW-1:0] exp_idx_r, exp_idx_nxt;
  logic [4:0]      drained_r, drained_nxt;
  logic [4:0]      window_r, window_nxt;
  logic            mode_r, mode_nxt;
  logic            out_valid_r, out_valid_nxt;
  rsp_t            out_r, out_nxt;

  logic [31:0]     seq_r, seq_nxt;
  logic [1:0]      type_r, type_nxt;
  logic [15:0]     tag_r, tag_nxt;
  logic [10:0]     len_r, len_nxt;

  // shared adder
  logic [31:0]     alu_a, alu_b;
  logic [32:0]     alu_sum;
  logic            carry;
  logic [31:0]     dmag;
  logic            win_drop;
  logic            in_store;
  logic [IDXW:0]   slot_sum;
  logic [IDXW-1:0] slot_idx;
  logic [31:0]     ack_val;

  store_cmd_t      cmd;
  store_sts_t      sts;
  slot_data_t      wdata, rdata;

  logic            accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // CMP: seq - expected (carry set when seq >= expected); INC: expected + 1
  assign alu_a   = (state_r == ST_CMP) ? seq_r : expected_r;
  assign alu_b   = (state_r == ST_CMP) ? ~expected_r : 32'd0;
  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + 33'd1;
  assign carry   = alu_sum[32];
  assign dmag    = alu_sum[31:0];

  assign win_drop = mode_r ? (dmag >= {27'd0, window_r}) : (dmag > {27'd0, window_r});
  assign in_store = (dmag < 32'(REORDER_SLOTS));

  // slot of a later packet: expected slot plus distance, wrapped once
  assign slot_sum = {1'b0, exp_idx_r} + {1'b0, dmag[IDXW-1:0]};
  assign slot_idx = (slot_sum >= SLOTS_W) ? IDXW'(slot_sum - SLOTS_W) : slot_sum[IDXW-1:0];

  assign ack_val = mode_r ? seq_r : expected_r;

  assign wdata.tag = tag_r;
  assign wdata.len = len_r;

  always_comb begin
    cmd.wr  = (state_r == ST_CMP) && (type_r == PT_DATA) && carry && !win_drop &&
              (dmag != 32'd0) && in_store && !sts.wr_full;
    cmd.rd  = (state_r == ST_PROBE) && sts.rd_full && (drained_r != MAX_DRAIN);
    cmd.clr = cmd.rd;
  end

  swr_store #(
    .REORDER_SLOTS (REORDER_SLOTS),
    .IDXW          (IDXW)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .waddr (slot_idx),
    .wdata (wdata),
    .raddr (exp_idx_r),
    .rdata (rdata),
    .sts   (sts)
  );

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    expected_nxt  = expected_r;
    exp_idx_nxt   = exp_idx_r;
    drained_nxt   = drained_r;
    window_nxt    = window_r;
    mode_nxt      = mode_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    seq_nxt       = seq_r;
    type_nxt      = type_r;
    tag_nxt       = tag_r;
    len_nxt       = len_r;

    if (cfg_we) begin
      case (cfg_addr)
        CFG_WINDOW: window_nxt = cfg_wdata;
        CFG_MODE:   mode_nxt   = cfg_wdata[0];
        default:    ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          seq_nxt  = in_req.seq;
          type_nxt = in_req.packet_type;
          tag_nxt  = in_req.payload_tag;
          len_nxt  = in_req.payload_len;
          if (phase_r == PH_WAIT) begin
            // opening request: ack its own number whatever it holds
            phase_nxt     = PH_OPEN;
            out_valid_nxt = 1'b1;
            out_nxt       = '{kind: KIND_ACK, ack_seq: in_req.seq, out_tag: 16'd0,
                              out_len: 11'd0, last: 1'b1};
          end else if ((phase_r == PH_OPEN) && in_req.header_ok &&
                       ((in_req.packet_type == PT_END) ||
                        (in_req.packet_type == PT_DATA))) begin
            state_nxt = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        state_nxt = ST_IDLE;
        // drop stale and out-of-window packets
        if (carry && !win_drop) begin
          if (type_r == PT_END) begin
            if (dmag == 32'd0) begin
              phase_nxt     = PH_CLOSED;
              out_valid_nxt = 1'b1;
              out_nxt       = '{kind: KIND_FINAL, ack_seq: seq_r, out_tag: 16'd0,
                                out_len: 11'd0, last: 1'b1};
            end
          end else if (dmag == 32'd0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{kind: KIND_DELIVER, ack_seq: 32'd0, out_tag: tag_r,
                              out_len: len_r, last: 1'b0};
            drained_nxt   = 5'd0;
            state_nxt     = ST_INC;
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{kind: KIND_ACK, ack_seq: ack_val, out_tag: 16'd0,
                              out_len: 11'd0, last: 1'b1};
          end
        end
      end
      ST_INC: begin
        expected_nxt = dmag;
        // counter wrap or the last slot restarts the slot index at zero
        if (carry || (exp_idx_r == IDX_LAST)) begin
          exp_idx_nxt = '0;
        end else begin
          exp_idx_nxt = exp_idx_r + IDXW'(1);
        end
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (cmd.rd) begin
          state_nxt = ST_READ;
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{kind: KIND_ACK, ack_seq: ack_val, out_tag: 16'd0,
                            out_len: 11'd0, last: 1'b1};
          state_nxt     = ST_IDLE;
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{kind: KIND_DELIVER, ack_seq: 32'd0, out_tag: rdata.tag,
                          out_len: rdata.len, last: 1'b0};
        drained_nxt   = drained_r + 5'd1;
        state_nxt     = ST_INC;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_WAIT;
      expected_r  <= 32'd0;
      exp_idx_r   <= '0;
      drained_r   <= 5'd0;
      window_r    <= WINDOW_RST;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      expected_r  <= expected_nxt;
      exp_idx_r   <= exp_idx_nxt;
      drained_r   <= drained_nxt;
      window_r    <= window_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r  <= out_nxt;
    seq_r  <= seq_nxt;
    type_r <= type_nxt;
    tag_r  <= tag_nxt;
    len_r  <= len_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  a_deliver_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.kind == KIND_DELIVER)) |-> !out_rsp.last)
    else $error("delivery marked as last result");

  a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.kind == KIND_FINAL)) |-> (phase_r == PH_CLOSED))
    else $error("final ack without closing the session");

  a_read_clears_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !sts.rd_full)
    else $error("drained slot still marked full");

  a_busy_open: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (phase_r == PH_OPEN))
    else $error("sequencer busy outside an open session");

endmodule
